@@ rtl/atrm_pkg.sv @@
// Shared types, codes and helper functions for the address translation rule table.
`timescale 1ns / 1ps

package atrm_pkg;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [5:0] PREFIX_MAX = 6'd32;

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic        kind;
        logic        slot_hit;
        logic        enable;
        logic [3:0]  slot;
        logic [31:0] first_ip;
        logic [15:0] first_port;
        logic [31:0] second_ip;
        logic [15:0] second_port;
        logic [31:0] third_ip;
        logic [15:0] third_port;
        logic [31:0] excluded_net;
        logic [5:0]  excluded_prefix;
    } item_t;

    // One stored rule.
    typedef struct packed {
        logic [31:0] local_ip;
        logic [15:0] local_port;
        logic [31:0] client_ip;
        logic [15:0] client_port;
        logic [31:0] out_ip;
        logic [15:0] out_port;
        logic [31:0] excl_net;
        logic [5:0]  excl_prefix;
    } rule_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic  valid;
        item_t entry;
    } queue_out_t;

    function automatic logic viewer_excluded(input logic [31:0] base,
                                             input logic [5:0] prefix,
                                             input logic [31:0] viewer);
        logic [31:0] mask;
        begin
            // A shift by 32 leaves zero, so a full prefix masks every bit.
            mask = ~(32'hFFFF_FFFF >> prefix);
            viewer_excluded = (prefix != 6'd0) && ((viewer & mask) == (base & mask));
        end
    endfunction

    function automatic logic rule_match(input rule_t r, input item_t k);
        begin
            rule_match = ((r.local_ip == 32'd0) || (r.local_ip == k.first_ip))
                && ((r.local_port == 16'd0) || (r.local_port == k.first_port))
                && ((r.client_ip == 32'd0) || (r.client_ip == k.second_ip))
                && ((r.client_port == 16'd0) || (r.client_port == k.second_port))
                && !viewer_excluded(r.excl_net, r.excl_prefix, k.third_ip);
        end
    endfunction

endpackage

@@ rtl/atrm_front.sv @@
// Front end: accepts input beats and classifies them for the back end.
`timescale 1ns / 1ps

module atrm_front #(
    parameter int RULES = 16
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [3:0]          s_slot,
    input  logic [31:0]         s_first_ip,
    input  logic [15:0]         s_first_port,
    input  logic [31:0]         s_second_ip,
    input  logic [15:0]         s_second_port,
    input  logic [31:0]         s_third_ip,
    input  logic [15:0]         s_third_port,
    input  logic [31:0]         s_excluded_net,
    input  logic [5:0]          s_excluded_prefix,
    input  logic                s_enable,
    input  logic                q_full,
    output logic                q_push,
    output atrm_pkg::item_t     q_entry
);
    import atrm_pkg::*;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_entry.kind        = s_kind;
        // Writes to a slot past the end of the table are dropped later.
        q_entry.slot_hit    = (32'(s_slot) < 32'(RULES));
        q_entry.enable      = s_enable;
        q_entry.slot        = s_slot;
        q_entry.first_ip    = s_first_ip;
        q_entry.first_port  = s_first_port;
        q_entry.second_ip   = s_second_ip;
        q_entry.second_port = s_second_port;
        q_entry.third_ip    = s_third_ip;
        q_entry.third_port  = s_third_port;
        q_entry.excluded_net = s_excluded_net;
        q_entry.excluded_prefix = (s_excluded_prefix > PREFIX_MAX) ? PREFIX_MAX
                                                                   : s_excluded_prefix;
    end

endmodule

@@ rtl/atrm_queue.sv @@
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps

module atrm_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  atrm_pkg::item_t        push_entry,
    output logic                   full,
    input  logic                   pop,
    output atrm_pkg::queue_out_t   head
);
    import atrm_pkg::*;

    item_t      slots_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign do_push    = push && !full;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.entry = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/atrm_back.sv @@
// Back end: rule table storage, sequential first-match scan and result register.
`timescale 1ns / 1ps

module atrm_back #(
    parameter int RULES = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  atrm_pkg::queue_out_t   head,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_result_ip,
    output logic [15:0]            m_result_port,
    output logic                   m_translated,
    output logic [3:0]             m_matched_slot
);
    import atrm_pkg::*;

    localparam int SLOT_W = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CNT_W  = $clog2(RULES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] chk_idx_reg, chk_idx_next;
    logic [RULES-1:0]  valid_reg, valid_next;
    item_t             key_reg, key_next;

    logic [31:0]       res_ip_reg, res_ip_next;
    logic [15:0]       res_port_reg, res_port_next;
    logic              res_tr_reg, res_tr_next;
    logic [3:0]        res_slot_reg, res_slot_next;

    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_ip_reg;
    logic [15:0]       m_port_reg;
    logic              m_tr_reg;
    logic [3:0]        m_slot_reg;
    logic              out_load;

    rule_t             mem [RULES];
    rule_t             rule_q;
    logic              rule_valid_q;
    logic              mem_we, mem_re;
    logic [SLOT_W-1:0] wr_idx;
    logic [SLOT_W-1:0] rd_addr;
    rule_t             wr_rule;
    logic [31:0]       slot_wide;
    logic [31:0]       chk_wide;
    logic              hit;

    assign slot_wide = 32'(head.entry.slot);
    assign wr_idx    = slot_wide[SLOT_W-1:0];
    assign rd_addr   = rd_idx_reg[SLOT_W-1:0];
    assign chk_wide  = 32'(chk_idx_reg);

    always_comb begin
        wr_rule.local_ip    = head.entry.first_ip;
        wr_rule.local_port  = head.entry.first_port;
        wr_rule.client_ip   = head.entry.second_ip;
        wr_rule.client_port = head.entry.second_port;
        wr_rule.out_ip      = head.entry.third_ip;
        wr_rule.out_port    = head.entry.third_port;
        wr_rule.excl_net    = head.entry.excluded_net;
        wr_rule.excl_prefix = head.entry.excluded_prefix;
    end

    // The compare works on the rule read in the previous cycle.
    assign hit = pend_reg && rule_valid_q && rule_match(rule_q, key_reg);

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        chk_idx_next  = chk_idx_reg;
        valid_next    = valid_reg;
        key_next      = key_reg;
        res_ip_next   = res_ip_reg;
        res_port_next = res_port_reg;
        res_tr_next   = res_tr_reg;
        res_slot_next = res_slot_reg;
        pop           = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    pop      = 1'b1;
                    key_next = head.entry;
                    if (head.entry.kind == KIND_WRITE) begin
                        if (head.entry.slot_hit) begin
                            if (head.entry.enable) begin
                                mem_we = 1'b1;
                                valid_next[wr_idx] = 1'b1;
                            end else begin
                                valid_next[wr_idx] = 1'b0;
                            end
                        end
                        res_ip_next   = 32'd0;
                        res_port_next = 16'd0;
                        res_tr_next   = 1'b0;
                        res_slot_next = 4'd0;
                        state_next    = ST_OUT;
                    end else begin
                        rd_idx_next = '0;
                        pend_next   = 1'b0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    res_ip_next   = rule_q.out_ip;
                    res_port_next = rule_q.out_port;
                    res_tr_next   = 1'b1;
                    res_slot_next = chk_wide[3:0];
                    pend_next     = 1'b0;
                    state_next    = ST_OUT;
                end else if (pend_reg && (chk_wide == 32'(RULES - 1))) begin
                    // No rule matched: pass the client address through.
                    res_ip_next   = key_reg.second_ip;
                    res_port_next = key_reg.second_port;
                    res_tr_next   = 1'b0;
                    res_slot_next = 4'd0;
                    pend_next     = 1'b0;
                    state_next    = ST_OUT;
                end else if (32'(rd_idx_reg) < 32'(RULES)) begin
                    mem_re       = 1'b1;
                    pend_next    = 1'b1;
                    chk_idx_next = rd_addr;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg  <= chk_idx_next;
        key_reg      <= key_next;
        res_ip_reg   <= res_ip_next;
        res_port_reg <= res_port_next;
        res_tr_reg   <= res_tr_next;
        res_slot_reg <= res_slot_next;
        if (out_load) begin
            m_ip_reg   <= res_ip_reg;
            m_port_reg <= res_port_reg;
            m_tr_reg   <= res_tr_reg;
            m_slot_reg <= res_slot_reg;
        end
    end

    // Rule storage: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx] <= wr_rule;
        end
        if (mem_re) begin
            rule_q       <= mem[rd_addr];
            rule_valid_q <= valid_reg[rd_addr];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_ip    = m_ip_reg;
    assign m_result_port  = m_port_reg;
    assign m_translated   = m_tr_reg;
    assign m_matched_slot = m_slot_reg;

endmodule

@@ rtl/address_translation_rule_match.sv @@
// A write beat and a lookup each give one result; a lookup scans the rules in turn,
// one rule per cycle, through the single read port of the rule store.
// The back end handles one beat at a time; the two-entry queue holds up to two
// further beats while it is busy.
// Reset: synchronous, active low; clears all rule valid bits, the queue and the
// output register. Rule contents are not cleared.
`timescale 1ns / 1ps

module address_translation_rule_match #(
    parameter int RULES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [3:0]  s_slot,
    input  logic [31:0] s_first_ip,
    input  logic [15:0] s_first_port,
    input  logic [31:0] s_second_ip,
    input  logic [15:0] s_second_port,
    input  logic [31:0] s_third_ip,
    input  logic [15:0] s_third_port,
    input  logic [31:0] s_excluded_net,
    input  logic [5:0]  s_excluded_prefix,
    input  logic        s_enable,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_ip,
    output logic [15:0] m_result_port,
    output logic        m_translated,
    output logic [3:0]  m_matched_slot
);
    import atrm_pkg::*;

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    item_t      q_entry;
    queue_out_t q_head;

    atrm_front #(
        .RULES(RULES)
    ) u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_slot           (s_slot),
        .s_first_ip       (s_first_ip),
        .s_first_port     (s_first_port),
        .s_second_ip      (s_second_ip),
        .s_second_port    (s_second_port),
        .s_third_ip       (s_third_ip),
        .s_third_port     (s_third_port),
        .s_excluded_net   (s_excluded_net),
        .s_excluded_prefix(s_excluded_prefix),
        .s_enable         (s_enable),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_entry          (q_entry)
    );

    atrm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    atrm_back #(
        .RULES(RULES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (q_head),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_ip   (m_result_ip),
        .m_result_port (m_result_port),
        .m_translated  (m_translated),
        .m_matched_slot(m_matched_slot)
    );

    // A result that did not translate never names a slot.
    a_slot_zero_untranslated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_translated |-> m_matched_slot == 4'd0)
        else $error("untranslated result carries a nonzero slot");

    // Reset empties the output register.
    a_reset_out_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Reset empties the queue, so the input side is ready.
    a_reset_in_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

@@ verif/atrm_tb_pkg.sv @@
// Beat types and the translation scoreboard for the rule table testbench.
`timescale 1ns / 1ps

package atrm_tb_pkg;

    import atrm_pkg::*;

    localparam int RULE_SLOTS = 16;

    typedef struct {
        logic        kind;
        logic [3:0]  slot;
        logic [31:0] first_ip;
        logic [15:0] first_port;
        logic [31:0] second_ip;
        logic [15:0] second_port;
        logic [31:0] third_ip;
        logic [15:0] third_port;
        logic [31:0] excluded_net;
        logic [5:0]  excluded_prefix;
        logic        enable;
    } nat_beat_t;

    typedef struct {
        logic [31:0] ip;
        logic [15:0] port;
        logic        translated;
        logic [3:0]  slot;
    } nat_result_t;

    typedef struct {
        logic [31:0] local_ip;
        logic [15:0] local_port;
        logic [31:0] client_ip;
        logic [15:0] client_port;
        logic [31:0] out_ip;
        logic [15:0] out_port;
        logic [31:0] excl_net;
        logic [5:0]  excl_len;
    } nat_rule_t;

    class xlate_scoreboard;
        bit          rule_live[RULE_SLOTS];
        nat_rule_t   rules[RULE_SLOTS];
        nat_result_t pending_translations[$];
        int          errors;

        function new();
            foreach (rule_live[i]) rule_live[i] = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return pending_translations.size();
        endfunction

        function bit viewer_blocked(nat_rule_t r, logic [31:0] viewer);
            logic [31:0] keep;
            if (r.excl_len == 6'd0) return 1'b0;
            keep = (r.excl_len == 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> r.excl_len);
            return (viewer & keep) == (r.excl_net & keep);
        endfunction

        function bit rule_fits(nat_rule_t r, nat_beat_t b);
            return (r.local_ip == 32'd0 || r.local_ip == b.first_ip)
                && (r.local_port == 16'd0 || r.local_port == b.first_port)
                && (r.client_ip == 32'd0 || r.client_ip == b.second_ip)
                && (r.client_port == 16'd0 || r.client_port == b.second_port)
                && !viewer_blocked(r, b.third_ip);
        endfunction

        // Updates the rule copy for a write beat and queues the result the beat must give.
        function void note_beat(nat_beat_t b);
            nat_result_t want;
            int hit;
            want.ip = '0;
            want.port = '0;
            want.translated = 1'b0;
            want.slot = '0;
            if (b.kind == KIND_WRITE) begin
                if (int'(b.slot) < RULE_SLOTS) begin
                    if (b.enable) begin
                        rules[b.slot].local_ip = b.first_ip;
                        rules[b.slot].local_port = b.first_port;
                        rules[b.slot].client_ip = b.second_ip;
                        rules[b.slot].client_port = b.second_port;
                        rules[b.slot].out_ip = b.third_ip;
                        rules[b.slot].out_port = b.third_port;
                        rules[b.slot].excl_net = b.excluded_net;
                        rules[b.slot].excl_len = (b.excluded_prefix > PREFIX_MAX) ?
                                                 PREFIX_MAX : b.excluded_prefix;
                    end
                    rule_live[b.slot] = b.enable;
                end
            end else begin
                hit = -1;
                for (int i = 0; i < RULE_SLOTS; i++) begin
                    if (hit < 0 && rule_live[i] && rule_fits(rules[i], b)) hit = i;
                end
                if (hit >= 0) begin
                    want.ip = rules[hit].out_ip;
                    want.port = rules[hit].out_port;
                    want.translated = 1'b1;
                    want.slot = hit[3:0];
                end else begin
                    want.ip = b.second_ip;
                    want.port = b.second_port;
                end
            end
            pending_translations.push_back(want);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(nat_result_t got);
            nat_result_t want;
            if (pending_translations.size() == 0) begin
                $error("unexpected result beat: ip %0h port %0h", got.ip, got.port);
                errors++;
                return;
            end
            want = pending_translations.pop_front();
            compare("result_ip", want.ip, got.ip);
            compare("result_port", 32'(want.port), 32'(got.port));
            compare("translated", 32'(want.translated), 32'(got.translated));
            compare("matched_slot", 32'(want.slot), 32'(got.slot));
        endfunction
    endclass

endpackage

@@ verif/tb_top.sv @@
// Top-level testbench for the first-match address translation rule table.
`timescale 1ns / 1ps

module tb_top;

    import atrm_pkg::*;
    import atrm_tb_pkg::*;

    localparam int RANDOM_BEATS = 1000;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 4000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [3:0]  s_slot;
    logic [31:0] s_first_ip;
    logic [15:0] s_first_port;
    logic [31:0] s_second_ip;
    logic [15:0] s_second_port;
    logic [31:0] s_third_ip;
    logic [15:0] s_third_port;
    logic [31:0] s_excluded_net;
    logic [5:0]  s_excluded_prefix;
    logic        s_enable;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_result_ip;
    logic [15:0] m_result_port;
    logic        m_translated;
    logic [3:0]  m_matched_slot;

    xlate_scoreboard sb = new();
    bit              long_hold_req = 1'b0;
    logic [31:0]     ip_pool[4];
    logic [15:0]     port_pool[4];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    address_translation_rule_match #(
        .RULES(RULE_SLOTS)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_slot            (s_slot),
        .s_first_ip        (s_first_ip),
        .s_first_port      (s_first_port),
        .s_second_ip       (s_second_ip),
        .s_second_port     (s_second_port),
        .s_third_ip        (s_third_ip),
        .s_third_port      (s_third_port),
        .s_excluded_net    (s_excluded_net),
        .s_excluded_prefix (s_excluded_prefix),
        .s_enable          (s_enable),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_ip       (m_result_ip),
        .m_result_port     (m_result_port),
        .m_translated      (m_translated),
        .m_matched_slot    (m_matched_slot)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic nat_beat_t rule_beat(logic [3:0] slot, logic [31:0] lip,
                                            logic [15:0] lport, logic [31:0] cip,
                                            logic [15:0] cport, logic [31:0] oip,
                                            logic [15:0] oport, logic [31:0] net,
                                            logic [5:0] plen, logic en);
        nat_beat_t b;
        b.kind = KIND_WRITE;
        b.slot = slot;
        b.first_ip = lip;
        b.first_port = lport;
        b.second_ip = cip;
        b.second_port = cport;
        b.third_ip = oip;
        b.third_port = oport;
        b.excluded_net = net;
        b.excluded_prefix = plen;
        b.enable = en;
        return b;
    endfunction

    // The fields a lookup ignores are filled with random values.
    function automatic nat_beat_t lookup_beat(logic [31:0] lip, logic [15:0] lport,
                                              logic [31:0] cip, logic [15:0] cport,
                                              logic [31:0] viewer);
        nat_beat_t b;
        b = rule_beat(4'($urandom), lip, lport, cip, cport, viewer, 16'($urandom),
                      $urandom, 6'($urandom), 1'($urandom));
        b.kind = KIND_LOOKUP;
        return b;
    endfunction

    function automatic logic [31:0] key_ip(bit wildcards);
        int roll;
        roll = $urandom_range(9);
        if (wildcards && roll < 3) return 32'd0;
        if (roll == 9) return $urandom;
        return ip_pool[$urandom_range(3)];
    endfunction

    function automatic logic [15:0] key_port(bit wildcards);
        int roll;
        roll = $urandom_range(9);
        if (wildcards && roll < 3) return 16'd0;
        if (roll == 9) return 16'($urandom);
        return port_pool[$urandom_range(3)];
    endfunction

    // Rule fields and lookup keys come from small pools so that lookups hit rules,
    // and viewers land on, near or far from the excluded networks.
    function automatic nat_beat_t next_random_beat();
        nat_beat_t b;
        int roll;
        logic [5:0] plen;
        roll = $urandom_range(99);
        if (roll < 8) begin
            b = rule_beat(4'($urandom), $urandom, 16'($urandom), $urandom, 16'($urandom),
                          $urandom, 16'($urandom), $urandom, 6'($urandom_range(32)),
                          1'($urandom));
            b.kind = logic'($urandom_range(1));
        end else if (roll < 38) begin
            roll = $urandom_range(99);
            plen = (roll < 20) ? 6'd0 : (roll < 35) ? 6'd32 : 6'($urandom_range(1, 31));
            b = rule_beat(4'($urandom), key_ip(1'b1), key_port(1'b1), key_ip(1'b1),
                          key_port(1'b1), $urandom, 16'($urandom), key_ip(1'b0), plen,
                          logic'($urandom_range(9) != 0));
        end else begin
            b = lookup_beat(key_ip(1'b0), key_port(1'b0), key_ip(1'b0), key_port(1'b0),
                            ip_pool[$urandom_range(3)]);
            roll = $urandom_range(9);
            if (roll < 3) b.third_ip = b.third_ip ^ (32'hFFFF_FFFF >> $urandom_range(1, 31));
            else if (roll < 6) b.third_ip = $urandom;
        end
        return b;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input nat_beat_t b, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_kind <= b.kind;
        s_slot <= b.slot;
        s_first_ip <= b.first_ip;
        s_first_port <= b.first_port;
        s_second_ip <= b.second_ip;
        s_second_port <= b.second_port;
        s_third_ip <= b.third_ip;
        s_third_port <= b.third_port;
        s_excluded_net <= b.excluded_net;
        s_excluded_prefix <= b.excluded_prefix;
        s_enable <= b.enable;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(b);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    initial begin : stimulus
        nat_beat_t directed_q[$];
        nat_beat_t b;
        bit gapped;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = KIND_WRITE;
        s_slot = '0;
        s_first_ip = '0;
        s_first_port = '0;
        s_second_ip = '0;
        s_second_port = '0;
        s_third_ip = '0;
        s_third_port = '0;
        s_excluded_net = '0;
        s_excluded_prefix = '0;
        s_enable = 1'b0;
        foreach (ip_pool[i]) begin
            do ip_pool[i] = $urandom; while (ip_pool[i] == 32'd0);
            do port_pool[i] = 16'($urandom); while (port_pool[i] == 16'd0);
        end

        // Empty table, then a catch-all rule in slot 0.
        directed_q.push_back(lookup_beat('1, '1, '1, '1, '1));
        directed_q.push_back(rule_beat(4'd0, '0, '0, '0, '0, '1, '1, '0, 6'd0, 1'b1));
        directed_q.push_back(lookup_beat('0, '0, '0, '0, '0));
        // Fully specified rule in the top slot that excludes one viewer address.
        directed_q.push_back(rule_beat(4'd15, '1, '1, '1, '1, 32'h1234_5678, 16'h0001,
                                       32'hC0A8_0001, 6'd32, 1'b1));
        // Disabling slot 0 must ignore the rule fields given with it.
        directed_q.push_back(rule_beat(4'd0, $urandom, 16'($urandom), $urandom,
                                       16'($urandom), $urandom, 16'($urandom), $urandom,
                                       6'd0, 1'b0));
        directed_q.push_back(lookup_beat('1, '1, '1, '1, 32'hC0A8_0002));
        directed_q.push_back(lookup_beat('1, '1, '1, '1, 32'hC0A8_0001));
        // A prefix beyond 32 acts like 32.
        directed_q.push_back(rule_beat(4'd15, '1, '1, '1, '1, 32'h1234_5678, 16'h0001,
                                       32'hC0A8_0001, 6'd63, 1'b1));
        directed_q.push_back(lookup_beat('1, '1, '1, '1, 32'hC0A8_0001));
        directed_q.push_back(lookup_beat('1, '1, '1, '1, 32'hC0A8_0000));
        // Port-only rule with an /8 exclusion.
        directed_q.push_back(rule_beat(4'd3, '0, 16'h1F90, '0, '0, 32'h0A0A_0A0A, 16'h0050,
                                       32'h0A00_0000, 6'd8, 1'b1));
        directed_q.push_back(lookup_beat(32'h0102_0304, 16'h1F90, 32'h0506_0708, 16'h1234,
                                         32'h0A12_3456));
        directed_q.push_back(lookup_beat(32'h0102_0304, 16'h1F90, 32'h0506_0708, 16'h1234,
                                         32'h0B00_0000));
        // A /1 exclusion on a lower slot; the lower slot wins whenever it fits.
        directed_q.push_back(rule_beat(4'd1, 32'h0102_0304, '0, 32'h0506_0708, '0,
                                       32'h0101_0101, 16'h0101, 32'h0000_0000, 6'd1, 1'b1));
        directed_q.push_back(lookup_beat(32'h0102_0304, 16'h1F90, 32'h0506_0708, 16'h1234,
                                         32'h7FFF_FFFF));
        directed_q.push_back(lookup_beat(32'h0102_0304, 16'h1F90, 32'h0506_0708, 16'h1234,
                                         32'h8000_0000));
        directed_q.push_back(rule_beat(4'd1, '0, '0, '0, '0, '0, '0, '0, 6'd0, 1'b0));
        directed_q.push_back(lookup_beat(32'h0102_0304, 16'h1F90, 32'h0506_0708, 16'h1234,
                                         32'h8000_0000));
        // Disabling a slot that was never written.
        directed_q.push_back(rule_beat(4'd7, '1, '1, '1, '1, '1, '1, '1, 6'd32, 1'b0));
        // Unused lookup fields at all ones.
        b = lookup_beat('0, '0, '0, '0, '0);
        b.slot = '1;
        b.third_port = '1;
        b.excluded_net = '1;
        b.excluded_prefix = '1;
        b.enable = 1'b1;
        directed_q.push_back(b);
        directed_q.push_back(rule_beat(4'd2, '0, '0, '0, '0, 32'hAAAA_AAAA, 16'h5555,
                                       32'h0000_0000, 6'd33, 1'b1));
        directed_q.push_back(lookup_beat('0, '0, '0, '0, 32'h0000_0000));
        directed_q.push_back(lookup_beat('0, '0, '0, '0, 32'h0000_0001));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_q[i]) begin
            send_beat(directed_q[i], ($urandom_range(2) == 0) ? gap_length() : 0);
        end
        wait_drained();

        gapped = 1'b0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 50 == 0) gapped = ($urandom_range(2) != 0);
            // The receiver holds off while beats keep coming, so the block backs up.
            if (n == 300) long_hold_req = 1'b1;
            if (n == 650) wait_drained();
            send_beat(next_random_beat(), (gapped && $urandom_range(9) < 4) ? gap_length() : 0);
        end

        wait_drained();
        repeat (RULE_SLOTS + 8) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : result_ready
        int hold_left;
        int stall_left;
        int stretch;
        bit stalling;
        m_ready = 1'b0;
        hold_left = 0;
        stall_left = 0;
        stretch = 0;
        stalling = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (stretch == 0) begin
                stalling = ($urandom_range(2) != 0);
                stretch = $urandom_range(10, 80);
            end
            stretch--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (stalling && $urandom_range(3) == 0) begin
                stall_left = gap_length() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        nat_result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.ip = m_result_ip;
            seen.port = m_result_port;
            seen.translated = m_translated;
            seen.slot = m_matched_slot;
            sb.check_result(seen);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/atrm_pkg.sv
rtl/atrm_front.sv
rtl/atrm_queue.sv
rtl/atrm_back.sv
rtl/address_translation_rule_match.sv
verif/atrm_tb_pkg.sv
verif/tb_top.sv
